@@ rtl/core/ptb_pkg.sv @@
package ptb_pkg;

   // Field and storage widths
   localparam int CMD_W    = 2;
   localparam int RATE_W   = 16;
   localparam int HND_W    = 32;
   localparam int ID_W     = 16;
   localparam int TICK_W   = 20;
   localparam int PERIOD_W = 26;
   localparam int REM_W    = 27;
   localparam int ROW_W    = HND_W + PERIOD_W + REM_W;

   localparam int NUM_TIMERS_DEF = 8;

   localparam logic [TICK_W-1:0]   TICK_RESET_US = TICK_W'(54925);
   localparam logic [PERIOD_W-1:0] US_PER_MS     = PERIOD_W'(1000);

   // Most negative remaining time; the countdown saturates here
   localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_CREATE = 2'd1,
      CMD_KILL   = 2'd2
   } cmd_type;

   typedef enum logic {
      CSR_TICK_PERIOD    = 1'b0,
      CSR_TIMERS_ENABLED = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_REPLY = 1'b0,
      KIND_FIRE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CREATE_SCAN,
      ST_KILL,
      ST_REPLY,
      ST_TICK_SCAN,
      ST_TICK_EXEC,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                fire;
      logic [REM_W-1:0]    rem_next;
      logic [PERIOD_W-1:0] period;
   } alu_out_type;

endpackage

@@ rtl/core/ptb_ram.sv @@
module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ptb_alu.sv @@
// Shared slot arithmetic: tick countdown with saturation and reload,
// and the period clamp used by create.
module ptb_alu (
   input  logic [ptb_pkg::REM_W-1:0]    rem,
   input  logic [ptb_pkg::PERIOD_W-1:0] period,
   input  logic [ptb_pkg::TICK_W-1:0]   tick,
   input  logic [ptb_pkg::PERIOD_W-1:0] prod,
   output ptb_pkg::alu_out_type         result
);

   localparam int RW = ptb_pkg::REM_W;
   localparam int PW = ptb_pkg::PERIOD_W;
   localparam int TW = ptb_pkg::TICK_W;

   logic signed [RW:0]   diff;
   logic signed [RW:0]   tick_ext;
   logic signed [RW:0]   min_ext;
   logic [RW-1:0]        sat;
   logic                 fire;

   always_comb begin
      tick_ext = $signed({{(RW+1-TW){1'b0}}, tick});
      min_ext  = $signed({ptb_pkg::REM_MIN[RW-1], ptb_pkg::REM_MIN});
      diff     = $signed({rem[RW-1], rem}) - tick_ext;
      sat      = (diff < min_ext) ? ptb_pkg::REM_MIN : diff[RW-1:0];
      fire     = sat[RW-1] || (sat == '0);

      result.fire     = fire;
      result.rem_next = fire ? (sat + {1'b0, period}) : sat;
      // create: never shorter than one tick
      result.period   = (prod < PW'(tick)) ? PW'(tick) : prod;
   end

endmodule

@@ rtl/core/periodic_timer_bank_top.sv @@
// Bank of NUM_TIMERS periodic timers counted in microseconds. A request
// carries cmd: tick (0) advances every active timer by the tick period
// and returns one fire response (kind 1, id, handler) per expiring slot in
// slot order, last set on the final one, or nothing if none fires or the
// timers are disabled; create (1) claims the lowest free slot with period
// max(rate_ms*1000, tick period) and replies with id slot+1 (0 when full);
// kill (2) frees an active slot and replies 0, otherwise echoes the id;
// cmd 3 is dropped. One request is processed at a time and req_stall is
// high while it runs. A create scans past occupied slots to the first free
// one, a kill checks the id and replies, and a tick walks every slot,
// skipping free ones, with one slot-table read and then one update
// through the shared arithmetic unit per active slot, then sends any held
// final fire; a stalled response port adds its wait. Slot contents live
// in a single-port-per-direction RAM with registered read, hence separate
// read and update steps. Config writes (csr_index 0 tick period, 1 enable)
// are always taken and belong only to idle periods.
module periodic_timer_bank_top #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ptb_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ptb_pkg::RATE_W-1:0]    req_rate_ms,
   input  logic [ptb_pkg::HND_W-1:0]     req_handler,
   input  logic [ptb_pkg::ID_W-1:0]      req_timer_id,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [ptb_pkg::ID_W-1:0]      rsp_value,
   output logic [ptb_pkg::HND_W-1:0]     rsp_fired_handler,
   output logic                          rsp_last,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [ptb_pkg::TICK_W-1:0]    csr_wdata
);

   localparam int AW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW  = $clog2(NUM_TIMERS + 1);
   localparam int IDW = ptb_pkg::ID_W;
   localparam int HW  = ptb_pkg::HND_W;
   localparam int PW  = ptb_pkg::PERIOD_W;
   localparam int RW  = ptb_pkg::REM_W;

   // Sequencer state
   ptb_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;

   // Latched request
   logic [PW-1:0]             prod_ff, prod_in;
   logic [HW-1:0]             hnd_ff, hnd_in;
   logic [IDW-1:0]            id_ff, id_in;
   logic [IDW-1:0]            reply_ff, reply_in;

   // Fire held back until we know whether it is the last one
   logic                      pend_vld_ff, pend_vld_in;
   logic [IDW-1:0]            pend_id_ff, pend_id_in;
   logic [HW-1:0]             pend_hnd_ff, pend_hnd_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [IDW-1:0]            rsp_value_ff, rsp_value_in;
   logic [HW-1:0]             rsp_hnd_ff, rsp_hnd_in;
   logic                      rsp_last_ff, rsp_last_in;

   // CSRs
   logic [ptb_pkg::TICK_W-1:0] tick_ff;
   logic                       enable_ff;

   // Slot table access
   logic                     ram_we, ram_re;
   logic [ptb_pkg::ROW_W-1:0] ram_wdata, ram_rdata;
   logic [HW-1:0]            rd_hnd;
   logic [PW-1:0]            rd_per;
   logic [RW-1:0]            rd_rem;
   ptb_pkg::alu_out_type     alu;

   logic                     req_accept;
   logic                     out_free;
   logic                     idx_end;
   logic [AW-1:0]            slot;
   logic                     cur_active;
   logic [IDW-1:0]           id_m1;
   logic [AW-1:0]            kill_slot;
   logic                     kill_ok;
   logic                     exec_go;

   assign req_stall  = (state_ff != ptb_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_end    = (idx_ff == CW'(NUM_TIMERS));
   assign slot       = idx_ff[AW-1:0];
   assign cur_active = !idx_end && active_ff[slot];
   assign id_m1      = id_ff - IDW'(1);
   assign kill_slot  = id_m1[AW-1:0];
   assign kill_ok    = (id_ff != '0) && (id_ff <= IDW'(NUM_TIMERS)) && active_ff[kill_slot];

   assign rd_hnd = ram_rdata[ptb_pkg::ROW_W-1 -: HW];
   assign rd_per = ram_rdata[RW +: PW];
   assign rd_rem = ram_rdata[RW-1:0];

   // A second fire cannot proceed while the response register is full
   assign exec_go = (state_ff == ptb_pkg::ST_TICK_EXEC) &&
                    !(alu.fire && pend_vld_ff && !out_free);

   ptb_ram #(
      .WIDTH (ptb_pkg::ROW_W),
      .DEPTH (NUM_TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   ptb_alu u_alu (
      .rem    (rd_rem),
      .period (rd_per),
      .tick   (tick_ff),
      .prod   (prod_ff),
      .result (alu)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptb_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  ptb_pkg::CMD_TICK:
                     state_in = enable_ff ? ptb_pkg::ST_TICK_SCAN : ptb_pkg::ST_IDLE;
                  ptb_pkg::CMD_CREATE: state_in = ptb_pkg::ST_CREATE_SCAN;
                  ptb_pkg::CMD_KILL:   state_in = ptb_pkg::ST_KILL;
                  default:             state_in = ptb_pkg::ST_IDLE;
               endcase
            end
         end
         ptb_pkg::ST_CREATE_SCAN: begin
            if (!cur_active) begin
               state_in = ptb_pkg::ST_REPLY;
            end
         end
         ptb_pkg::ST_KILL: state_in = ptb_pkg::ST_REPLY;
         ptb_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = ptb_pkg::ST_IDLE;
            end
         end
         ptb_pkg::ST_TICK_SCAN: begin
            if (idx_end) begin
               state_in = pend_vld_ff ? ptb_pkg::ST_FLUSH : ptb_pkg::ST_IDLE;
            end else if (cur_active) begin
               state_in = ptb_pkg::ST_TICK_EXEC;
            end
         end
         ptb_pkg::ST_TICK_EXEC: begin
            if (exec_go) begin
               state_in = ptb_pkg::ST_TICK_SCAN;
            end
         end
         ptb_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = ptb_pkg::ST_IDLE;
            end
         end
         default: state_in = ptb_pkg::ST_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      idx_in       = idx_ff;
      active_in    = active_ff;
      prod_in      = prod_ff;
      hnd_in       = hnd_ff;
      id_in        = id_ff;
      reply_in     = reply_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      pend_hnd_in  = pend_hnd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_hnd_in   = rsp_hnd_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wdata    = {hnd_ff, alu.period, {1'b0, alu.period}};

      unique case (state_ff)
         ptb_pkg::ST_IDLE: begin
            if (req_accept) begin
               prod_in     = PW'(req_rate_ms) * ptb_pkg::US_PER_MS;
               hnd_in      = req_handler;
               id_in       = req_timer_id;
               idx_in      = '0;
               pend_vld_in = 1'b0;
            end
         end
         ptb_pkg::ST_CREATE_SCAN: begin
            if (idx_end) begin
               reply_in = '0;
            end else if (!active_ff[slot]) begin
               // zero handler: row written, slot stays free
               ram_we          = 1'b1;
               active_in[slot] = (hnd_ff != '0);
               reply_in        = IDW'(idx_ff) + IDW'(1);
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ptb_pkg::ST_KILL: begin
            if (kill_ok) begin
               active_in[kill_slot] = 1'b0;
               reply_in             = '0;
            end else begin
               reply_in = id_ff;
            end
         end
         ptb_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ptb_pkg::KIND_REPLY;
               rsp_value_in = reply_ff;
               rsp_hnd_in   = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ptb_pkg::ST_TICK_SCAN: begin
            if (!idx_end) begin
               if (active_ff[slot]) begin
                  ram_re = 1'b1;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         ptb_pkg::ST_TICK_EXEC: begin
            ram_wdata = {rd_hnd, rd_per, alu.rem_next};
            if (exec_go) begin
               ram_we = 1'b1;
               idx_in = idx_ff + CW'(1);
               if (alu.fire) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptb_pkg::KIND_FIRE;
                     rsp_value_in = pend_id_ff;
                     rsp_hnd_in   = pend_hnd_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = IDW'(idx_ff) + IDW'(1);
                  pend_hnd_in = rd_hnd;
               end
            end
         end
         ptb_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ptb_pkg::KIND_FIRE;
               rsp_value_in = pend_id_ff;
               rsp_hnd_in   = pend_hnd_ff;
               rsp_last_in  = 1'b1;
               pend_vld_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptb_pkg::ST_IDLE;
         active_ff    <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      hnd_ff       <= hnd_in;
      id_ff        <= id_in;
      reply_ff     <= reply_in;
      pend_id_ff   <= pend_id_in;
      pend_hnd_ff  <= pend_hnd_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hnd_ff   <= rsp_hnd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // CSR writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= ptb_pkg::TICK_RESET_US;
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ptb_pkg::CSR_TICK_PERIOD:    tick_ff   <= csr_wdata;
            ptb_pkg::CSR_TIMERS_ENABLED: enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_fired_handler = rsp_hnd_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ rtl/core/ptb_checker.sv @@
module ptb_checker #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [ptb_pkg::CMD_W-1:0]  req_cmd,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_kind,
   input logic [ptb_pkg::ID_W-1:0]   rsp_value,
   input logic [ptb_pkg::HND_W-1:0]  rsp_fired_handler,
   input logic                       rsp_last
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Create and kill always answer and keep the request side busy meanwhile
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_cmd == ptb_pkg::CMD_CREATE || req_cmd == ptb_pkg::CMD_KILL) |=> req_stall)
      else $error("command accepted without going busy");

   // A reply is a single response with zero handler
   a_reply_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ptb_pkg::KIND_REPLY) |-> rsp_last && (rsp_fired_handler == '0))
      else $error("malformed command reply");

   // A fire names an existing slot with a live handler
   a_fire_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ptb_pkg::KIND_FIRE) |->
      (rsp_value != '0) && (rsp_value <= ptb_pkg::ID_W'(NUM_TIMERS)) &&
      (rsp_fired_handler != '0))
      else $error("malformed fire response");

endmodule

bind periodic_timer_bank_top ptb_checker #(
   .NUM_TIMERS (NUM_TIMERS)
) u_ptb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_cmd           (req_cmd),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_value         (rsp_value),
   .rsp_fired_handler (rsp_fired_handler),
   .rsp_last          (rsp_last)
);

@@ tb/periodic_timer_bank_top_tb.sv @@
`timescale 1ns / 100ps

module periodic_timer_bank_top_tb;
   import ptb_pkg::*;

   localparam int NUM_SLOTS    = NUM_TIMERS_DEF;
   localparam int MAX_PAUSE    = 17;
   // worst busy time with no response: a tick over a full bank
   localparam int DRAIN_CYCLES = 40;
   // cycles with no handshake of any kind before the run is declared hung
   localparam int HANG_LIMIT   = 2000;

   // cmd 3 has no package name; the block drops it
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   // remaining time saturates at the least 27-bit value
   localparam longint LEFT_FLOOR = -(longint'(1) << (REM_W - 1));

   typedef struct packed {
      kind_type         kind;
      logic [ID_W-1:0]  value;
      logic [HND_W-1:0] hnd;
      logic             last;
   } timer_result_type;

   // one directed request; pinned rows carry their reply typed in
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [RATE_W-1:0] rate;
      logic [HND_W-1:0]  hnd;
      logic [ID_W-1:0]   id;
      logic              pinned;
      logic [ID_W-1:0]   reply;
   } probe_row_type;

   // one random phase: register settings, request count, share of ticks (%)
   typedef struct packed {
      logic [TICK_W-1:0] tick_us;
      logic              enabled;
      logic [7:0]        count;
      logic [6:0]        tick_pct;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd      = '0;
   logic [RATE_W-1:0]    req_rate_ms  = '0;
   logic [HND_W-1:0]     req_handler  = '0;
   logic [ID_W-1:0]      req_timer_id = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_kind;
   logic [ID_W-1:0]      rsp_value;
   logic [HND_W-1:0]     rsp_fired_handler;
   logic                 rsp_last;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_index = 1'b0;
   logic [TICK_W-1:0]    csr_wdata = '0;

   always #6 clock = ~clock;

   periodic_timer_bank_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_rate_ms       (req_rate_ms),
      .req_handler       (req_handler),
      .req_timer_id      (req_timer_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow of the timer bank: slot table plus the two registers
   // ---------------------------------------------------------------------
   logic [HND_W-1:0]        bank_handler [NUM_SLOTS];
   logic [PERIOD_W-1:0]     bank_period  [NUM_SLOTS];
   logic signed [REM_W-1:0] bank_left    [NUM_SLOTS];
   logic [TICK_W-1:0]       cfg_tick_us;
   logic                    cfg_ticks_on;

   timer_result_type step_results    [$];   // results of the request just taken
   timer_result_type awaited_results [$];   // in order, oldest first

   logic             failed = 1'b0;
   logic             steady = 1'b0;         // high: no pauses on either side
   logic             pin_on = 1'b0;         // current request has a typed reply
   logic [ID_W-1:0]  pin_reply = '0;
   int               dead_cycles = 0;

   // Applies one request to the shadow bank and leaves its results in
   // step_results.
   task automatic run_bank_model(input logic [CMD_W-1:0] cmd,
                                 input logic [RATE_W-1:0] rate,
                                 input logic [HND_W-1:0] hnd,
                                 input logic [ID_W-1:0] id);
      longint              left;
      logic [PERIOD_W-1:0] want;
      logic [ID_W-1:0]     reply;
      logic                claimed;
      timer_result_type    tail;
      step_results.delete();
      case (cmd)
         CMD_TICK: begin
            if (cfg_ticks_on) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (bank_handler[i] != '0) begin
                     left = longint'(bank_left[i]) - longint'(cfg_tick_us);
                     if (left < LEFT_FLOOR)
                        left = LEFT_FLOOR;
                     if (left <= 0) begin
                        left += longint'(bank_period[i]);
                        step_results.push_back(timer_result_type'{
                           kind: KIND_FIRE, value: ID_W'(i + 1),
                           hnd: bank_handler[i], last: 1'b0});
                     end
                     bank_left[i] = REM_W'(left);
                  end
               end
               if (step_results.size() != 0) begin
                  tail = step_results.pop_back();
                  tail.last = 1'b1;
                  step_results.push_back(tail);
               end
            end
         end
         CMD_CREATE: begin
            reply = '0;
            claimed = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!claimed && bank_handler[i] == '0) begin
                  want = PERIOD_W'(rate) * US_PER_MS;
                  if (want < PERIOD_W'(cfg_tick_us))
                     want = PERIOD_W'(cfg_tick_us);
                  bank_period[i]  = want;
                  bank_left[i]    = REM_W'(want);
                  // a zero handler leaves the slot free
                  bank_handler[i] = hnd;
                  reply   = ID_W'(i + 1);
                  claimed = 1'b1;
               end
            end
            step_results.push_back(timer_result_type'{
               kind: KIND_REPLY, value: reply, hnd: '0, last: 1'b1});
         end
         CMD_KILL: begin
            reply = id;
            if (id != '0 && id <= ID_W'(NUM_SLOTS) && bank_handler[id - 1] != '0) begin
               bank_handler[id - 1] = '0;
               reply = '0;
            end
            step_results.push_back(timer_result_type'{
               kind: KIND_REPLY, value: reply, hnd: '0, last: 1'b1});
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: everything sampled at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : track_bank
      timer_result_type want;
      if (reset) begin
         cfg_tick_us  = TICK_RESET_US;
         cfg_ticks_on = 1'b1;
         for (int i = 0; i < NUM_SLOTS; i++)
            bank_handler[i] = '0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_PERIOD:    cfg_tick_us  = csr_wdata;
               CSR_TIMERS_ENABLED: cfg_ticks_on = csr_wdata[0];
            endcase
         end
         // responses first: none can belong to a request taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected response: kind %0d value %0d handler %h",
                      rsp_kind, rsp_value, rsp_fired_handler);
               failed = 1'b1;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
                  failed = 1'b1;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  failed = 1'b1;
               end
               if (rsp_fired_handler !== want.hnd) begin
                  $error("fired_handler: expected %h, actual %h",
                         want.hnd, rsp_fired_handler);
                  failed = 1'b1;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // the shadow always advances; a typed reply replaces its answer
            run_bank_model(req_cmd, req_rate_ms, req_handler, req_timer_id);
            if (pin_on)
               awaited_results.push_back(timer_result_type'{
                  kind: KIND_REPLY, value: pin_reply, hnd: '0, last: 1'b1});
            else
               foreach (step_results[k])
                  awaited_results.push_back(step_results[k]);
         end
      end
   end

   // Hang detector: counts edges where nothing at all is handed over
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         dead_cycles <= 0;
      end else begin
         dead_cycles <= dead_cycles + 1;
         if (dead_cycles == HANG_LIMIT) begin
            $display("periodic_timer_bank_top: mismatch");
            $finish;
         end
      end
   end

   function automatic int pause_draw();
      return steady ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   // ---------------------------------------------------------------------
   // Response side: stall for a drawn number of cycles in which a response
   // is actually offered, so the stalls land on real results
   // ---------------------------------------------------------------------
   initial begin : pace_responses
      int hold;
      @(negedge clock);
      forever begin
         hold = pause_draw();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            while (hold != 0) begin
               @(posedge clock);
               if (rsp_valid)
                  hold--;
               @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after the
   // request is taken, valid still high so a zero pause chains requests.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [RATE_W-1:0] rate,
                               input logic [HND_W-1:0] hnd,
                               input logic [ID_W-1:0] id,
                               input logic pinned,
                               input logic [ID_W-1:0] reply);
      int pause;
      pause = pause_draw();
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_rate_ms  <= rate;
      req_handler  <= hnd;
      req_timer_id <= id;
      pin_on    = pinned;
      pin_reply = reply;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic send_random(input int tick_pct);
      logic [CMD_W-1:0]  cmd;
      logic [RATE_W-1:0] rate;
      logic [HND_W-1:0]  hnd;
      logic [ID_W-1:0]   id;
      int                pick;
      int                rate_span;
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
         cmd = CMD_TICK;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            cmd = CMD_SPARE;
         else if (pick < 10)
            cmd = CMD_CREATE;
         else
            cmd = CMD_KILL;
      end
      // mostly periods of a few ticks so timers fire often; now and then
      // anything the field holds
      rate_span = int'(cfg_tick_us) * 8 / 1000 + 1;
      if ($urandom_range(0, 7) == 0)
         rate = RATE_W'($urandom);
      else
         rate = RATE_W'($urandom_range(0, rate_span));
      hnd = ($urandom_range(0, 11) == 0) ? '0 : HND_W'($urandom);
      case ($urandom_range(0, 9))
         0:       id = ID_W'($urandom);
         1:       id = '0;
         default: id = ID_W'($urandom_range(1, NUM_SLOTS));
      endcase
      send_request(cmd, rate, hnd, id, 1'b0, '0);
   endtask

   // Lets the bank go idle: every result in, then time for a tick that
   // fires nothing to finish its walk.
   task automatic drain_bank();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_csr(input csr_index_type idx, input logic [TICK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
   endtask

   // Directed requests at reset settings (tick 54925 us, timers on)
   probe_row_type probe_rows [23] = '{
      // kill on an empty bank: zero, a free slot, top of field, one past end
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd0,    1'b1, 16'd0},
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd3,    1'b1, 16'd3},
      '{CMD_KILL,   16'hFFFF,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF},
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd9,    1'b1, 16'd9},
      // zero rate clamps to the tick period; full rate is the longest period
      '{CMD_CREATE, 16'd0,     32'hFFFF_FFFF, 16'd0,    1'b1, 16'd1},
      '{CMD_CREATE, 16'hFFFF,  32'h0000_0001, 16'd0,    1'b1, 16'd2},
      // zero handler: id handed out, slot stays free and is handed out again
      '{CMD_CREATE, 16'd100,   32'h0000_0000, 16'd0,    1'b1, 16'd3},
      '{CMD_CREATE, 16'd55,    32'hA5A5_5A5A, 16'd0,    1'b1, 16'd3},
      // just under the tick period, so clamped
      '{CMD_CREATE, 16'd54,    32'h5A5A_A5A5, 16'd0,    1'b1, 16'd4},
      '{CMD_TICK,   16'd0,     32'h0000_0000, 16'd0,    1'b0, 16'd0},
      // unused command: dropped, no response
      '{CMD_SPARE,  16'hFFFF,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'd0},
      '{CMD_TICK,   16'd0,     32'h0000_0000, 16'd0,    1'b0, 16'd0},
      // fill the bank, then one create too many
      '{CMD_CREATE, 16'd1,     32'h0000_8000, 16'd0,    1'b1, 16'd5},
      '{CMD_CREATE, 16'd2,     32'h8000_0000, 16'd0,    1'b1, 16'd6},
      '{CMD_CREATE, 16'd1000,  32'h1234_5678, 16'd0,    1'b1, 16'd7},
      '{CMD_CREATE, 16'd30000, 32'hFEDC_BA98, 16'd0,    1'b1, 16'd8},
      '{CMD_CREATE, 16'd10,    32'h0BAD_F00D, 16'd0,    1'b1, 16'd0},
      // kill the last slot, then again once it is free
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd8,    1'b1, 16'd0},
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd8,    1'b1, 16'd8},
      '{CMD_TICK,   16'd0,     32'h0000_0000, 16'd0,    1'b0, 16'd0},
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd1,    1'b1, 16'd0},
      '{CMD_KILL,   16'd0,     32'h0000_0000, 16'd2,    1'b1, 16'd0},
      '{CMD_TICK,   16'd0,     32'h0000_0000, 16'd0,    1'b0, 16'd0}
   };

   // Register settings walked by the random part. Tick 0 gives period-0
   // timers that fire on every tick; the full-field tick period outruns the
   // short periods left from earlier phases and drives remaining time into
   // saturation, hence the long tick-heavy run there.
   phase_type phase_plan [7] = '{
      '{20'd54925,   1'b1, 8'd15, 7'd40},
      '{20'd1000,    1'b1, 8'd15, 7'd40},
      '{20'd1,       1'b1, 8'd15, 7'd40},
      '{20'd0,       1'b1, 8'd15, 7'd50},
      '{20'hFFFFF,   1'b1, 8'd90, 7'd97},
      '{20'd54925,   1'b0, 8'd12, 7'd50},
      '{20'd54925,   1'b1, 8'd15, 7'd40}
   };

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (probe_rows[r])
         send_request(probe_rows[r].cmd, probe_rows[r].rate, probe_rows[r].hnd,
                      probe_rows[r].id, probe_rows[r].pinned, probe_rows[r].reply);

      foreach (phase_plan[p]) begin
         // registers change only with the bank idle
         drain_bank();
         write_csr(CSR_TICK_PERIOD, phase_plan[p].tick_us);
         write_csr(CSR_TIMERS_ENABLED, TICK_W'(phase_plan[p].enabled));
         csr_valid <= 1'b0;
         steady = ($urandom_range(0, 3) == 0);
         repeat (int'(phase_plan[p].count)) begin
            // switch between paced and back-to-back stretches now and then
            if ($urandom_range(0, 15) == 0)
               steady = !steady;
            send_random(int'(phase_plan[p].tick_pct));
         end
      end

      drain_bank();
      if (!failed)
         $display("periodic_timer_bank_top: match");
      else
         $display("periodic_timer_bank_top: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ptb_pkg.sv
rtl/core/ptb_ram.sv
rtl/core/ptb_alu.sv
rtl/core/periodic_timer_bank_top.sv
rtl/core/ptb_checker.sv
tb/periodic_timer_bank_top_tb.sv
